FILE: rtl/tdh_pkg.sv
// Shared constants and the month offset table for the timestamp difference block.
// No dependencies; used by tdh_secs and timestamp_difference_hms.
package tdh_pkg;

    localparam int                TOD_BITS    = 17;
    localparam int                LANE_STAGES = 4;
    localparam int                HOURS_BITS  = 27;
    localparam int                X_BITS      = 35;
    localparam int                RECIP_SHIFT = 35;
    localparam logic [27:0]       RECIP_225   = 28'd152709948;
    localparam logic [12:0]       RECIP_60    = 13'd4369;
    localparam logic [63:0]       SAT_SECONDS = 64'd483183820800;
    localparam logic [HOURS_BITS-1:0] HOURS_MAX = '1;

    function automatic logic [8:0] month_offset(input logic [3:0] month);
        logic [8:0] days;
        unique case (month)
            4'd0, 4'd1: days = 9'd0;
            4'd2:       days = 9'd31;
            4'd3:       days = 9'd59;
            4'd4:       days = 9'd90;
            4'd5:       days = 9'd120;
            4'd6:       days = 9'd151;
            4'd7:       days = 9'd181;
            4'd8:       days = 9'd212;
            4'd9:       days = 9'd243;
            4'd10:      days = 9'd273;
            4'd11:      days = 9'd304;
            4'd12:      days = 9'd334;
            default:    days = 9'd365;
        endcase
        return days;
    endfunction

endpackage

FILE: rtl/tdh_secs.sv
// Four-stage pipeline that turns one timestamp into seconds since the start of year 0.
// Depends on tdh_pkg; instantiated twice by timestamp_difference_hms.
module tdh_secs #(
    parameter int YEAR_BITS = 14
) (
    input  logic                  clk,
    input  logic                  adv,
    input  logic [YEAR_BITS-1:0]  year,
    input  logic [3:0]            month,
    input  logic [4:0]            day,
    input  logic [4:0]            hour,
    input  logic [5:0]            minute,
    input  logic [5:0]            second,
    output logic [YEAR_BITS+25:0] secs
);

    localparam int TW = YEAR_BITS + 1;
    localparam int MW = TW - 6;
    localparam int DW = YEAR_BITS + 9;
    localparam int SW = YEAR_BITS + 26;
    localparam int PW = TW + MW;
    localparam logic [MW-1:0] RECIP_100 = MW'((1 << TW) / 100);

    // stage 1
    logic [TW-1:0]                  t_next;
    logic [TW-1:0]                  q4_next;
    logic [DW-1:0]                  base_next;
    logic [tdh_pkg::TOD_BITS-1:0]   tod_next;
    logic [TW-1:0]                  t_reg;
    logic [PW-1:0]                  prod_reg;
    logic [1:0]                     ylow_reg;
    logic                           late_reg;
    logic [DW-1:0]                  base_reg;
    logic [tdh_pkg::TOD_BITS-1:0]   tod_reg;

    // stage 2
    logic [MW-1:0]                  q_est;
    logic [TW-1:0]                  rem_full;
    logic [TW-1:0]                  rem_cor;
    logic                           fix;
    logic [MW-1:0]                  q100_next;
    logic                           leap;
    logic [MW-1:0]                  q100_reg;
    logic                           leap_add_reg;
    logic [DW-1:0]                  base2_reg;
    logic [tdh_pkg::TOD_BITS-1:0]   tod2_reg;

    // stage 3
    logic [MW-1:0]                  q400;
    logic [DW-1:0]                  days_next;
    logic [DW-1:0]                  days_reg;
    logic [tdh_pkg::TOD_BITS-1:0]   tod3_reg;

    // stage 4
    logic [SW-1:0]                  secs_next;
    logic [SW-1:0]                  secs_reg;

    always_comb
    begin
        t_next    = TW'(year) + TW'(99);
        q4_next   = (TW'(year) + TW'(3)) >> 2;
        base_next = DW'(year) * DW'(365) + DW'(q4_next)
                  + DW'(tdh_pkg::month_offset(month)) + DW'(day);
        tod_next  = tdh_pkg::TOD_BITS'(hour) * tdh_pkg::TOD_BITS'(3600)
                  + tdh_pkg::TOD_BITS'(minute) * tdh_pkg::TOD_BITS'(60)
                  + tdh_pkg::TOD_BITS'(second);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg    <= t_next;
            prod_reg <= PW'(t_next) * PW'(RECIP_100);
            ylow_reg <= year[1:0];
            late_reg <= (month >= 4'd3);
            base_reg <= base_next;
            tod_reg  <= tod_next;
        end
    end

    // divide by 100: reciprocal estimate, then one correction step
    always_comb
    begin
        q_est     = prod_reg[PW-1:TW];
        rem_full  = t_reg - TW'(q_est) * TW'(100);
        fix       = (rem_full >= TW'(100));
        q100_next = fix ? q_est + MW'(1) : q_est;
        rem_cor   = fix ? rem_full - TW'(100) : rem_full;
        leap      = (ylow_reg == 2'd0) && ((rem_cor != TW'(99)) || (q100_next[1:0] == 2'd0));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q100_reg     <= q100_next;
            leap_add_reg <= leap && late_reg;
            base2_reg    <= base_reg;
            tod2_reg     <= tod_reg;
        end
    end

    always_comb
    begin
        q400      = (q100_reg + MW'(3)) >> 2;
        days_next = base2_reg + DW'(q400) - DW'(q100_reg) + DW'(leap_add_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            days_reg <= days_next;
            tod3_reg <= tod2_reg;
        end
    end

    always_comb
    begin
        secs_next = SW'(days_reg) * SW'(86400) + SW'(tod3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            secs_reg <= secs_next;
        end
    end

    assign secs = secs_reg;

endmodule

FILE: rtl/timestamp_difference_hms.sv
// Top level of the timestamp difference block: two timestamp lanes, difference and h/m/s split.
// Depends on tdh_pkg and tdh_secs.
//
// Takes one pair of calendar timestamps per beat and returns the absolute difference
// as whole hours, minutes and seconds. One beat enters per clock cycle while the pipeline
// is not held; four stages form each timestamp's second count, and six take the difference
// and divide it by 3600 and then by 60. The whole
// pipeline holds while a result waits on out_ready, so in_ready follows out_ready
// whenever the last stage is full. Fields are not range checked; a difference beyond
// the hours field saturates to all ones with 59 minutes and 59 seconds.
module timestamp_difference_hms #(
    parameter int YEAR_BITS = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [YEAR_BITS-1:0]  year_a,
    input  logic [3:0]            month_a,
    input  logic [4:0]            day_a,
    input  logic [4:0]            hour_a,
    input  logic [5:0]            minute_a,
    input  logic [5:0]            second_a,
    input  logic [YEAR_BITS-1:0]  year_b,
    input  logic [3:0]            month_b,
    input  logic [4:0]            day_b,
    input  logic [4:0]            hour_b,
    input  logic [5:0]            minute_b,
    input  logic [5:0]            second_b,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [26:0]           diff_hours,
    output logic [5:0]            diff_minutes,
    output logic [5:0]            diff_seconds
);

    localparam int SW     = YEAR_BITS + 26;
    localparam int STAGES = tdh_pkg::LANE_STAGES + 6;
    localparam int HB     = tdh_pkg::HOURS_BITS;
    localparam int XB     = tdh_pkg::X_BITS;

    logic               adv;
    logic [STAGES-1:0]  v_reg;
    logic [SW-1:0]      secs_a;
    logic [SW-1:0]      secs_b;

    // difference
    logic [SW-1:0]      diff_reg;

    // reciprocal multiply by 1/225
    logic [63:0]        diff_ext;
    logic [XB-1:0]      x_next;
    logic [45:0]        pp_hi_reg;
    logic [44:0]        pp_lo_reg;
    logic [XB-1:0]      x_reg;
    logic [3:0]         low4_reg;
    logic               sat_reg;

    logic [62:0]        prod;
    logic [HB-1:0]      q_est_reg;
    logic [XB-1:0]      x2_reg;
    logic [3:0]         low4b_reg;
    logic               sat2_reg;

    logic [XB-1:0]      r225;
    logic               fix225;
    logic [7:0]         rem225;
    logic [HB-1:0]      hours_next;
    logic [11:0]        rest_next;
    logic [HB-1:0]      hours_reg;
    logic [11:0]        rest_reg;
    logic               sat3_reg;

    logic [24:0]        mprod;
    logic [5:0]         min_est_reg;
    logic [11:0]        rest2_reg;
    logic [HB-1:0]      hours2_reg;
    logic               sat4_reg;

    logic [11:0]        r60;
    logic               fix60;
    logic [HB-1:0]      out_hours_reg;
    logic [5:0]         out_minutes_reg;
    logic [5:0]         out_seconds_reg;

    assign adv      = !v_reg[STAGES-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[STAGES-2:0], in_valid};
        end
    end

    tdh_secs #(
        .YEAR_BITS (YEAR_BITS)
    ) u_lane_a (
        .clk    (clk),
        .adv    (adv),
        .year   (year_a),
        .month  (month_a),
        .day    (day_a),
        .hour   (hour_a),
        .minute (minute_a),
        .second (second_a),
        .secs   (secs_a)
    );

    tdh_secs #(
        .YEAR_BITS (YEAR_BITS)
    ) u_lane_b (
        .clk    (clk),
        .adv    (adv),
        .year   (year_b),
        .month  (month_b),
        .day    (day_b),
        .hour   (hour_b),
        .minute (minute_b),
        .second (second_b),
        .secs   (secs_b)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff_reg <= (secs_b >= secs_a) ? secs_b - secs_a : secs_a - secs_b;
        end
    end

    // drop the low four bits (3600 = 16 * 225) and split the multiply in two
    always_comb
    begin
        diff_ext = 64'(diff_reg);
        x_next   = diff_ext[XB+3:4];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_hi_reg <= 46'(x_next[XB-1:17]) * 46'(tdh_pkg::RECIP_225);
            pp_lo_reg <= 45'(x_next[16:0]) * 45'(tdh_pkg::RECIP_225);
            x_reg     <= x_next;
            low4_reg  <= diff_ext[3:0];
            sat_reg   <= (diff_ext >= tdh_pkg::SAT_SECONDS);
        end
    end

    assign prod = {pp_hi_reg, 17'b0} + 63'(pp_lo_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_est_reg <= prod[tdh_pkg::RECIP_SHIFT+HB-1:tdh_pkg::RECIP_SHIFT];
            x2_reg    <= x_reg;
            low4b_reg <= low4_reg;
            sat2_reg  <= sat_reg;
        end
    end

    always_comb
    begin
        r225       = x2_reg - XB'(q_est_reg) * XB'(225);
        fix225     = (r225 >= XB'(225));
        hours_next = fix225 ? q_est_reg + HB'(1) : q_est_reg;
        rem225     = fix225 ? 8'(r225 - XB'(225)) : 8'(r225);
        rest_next  = {rem225, low4b_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hours_reg <= hours_next;
            rest_reg  <= rest_next;
            sat3_reg  <= sat2_reg;
        end
    end

    assign mprod = 25'(rest_reg) * 25'(tdh_pkg::RECIP_60);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            min_est_reg <= mprod[23:18];
            rest2_reg   <= rest_reg;
            hours2_reg  <= hours_reg;
            sat4_reg    <= sat3_reg;
        end
    end

    always_comb
    begin
        r60   = rest2_reg - 12'(min_est_reg) * 12'(60);
        fix60 = (r60 >= 12'(60));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (sat4_reg)
            begin
                out_hours_reg   <= tdh_pkg::HOURS_MAX;
                out_minutes_reg <= 6'd59;
                out_seconds_reg <= 6'd59;
            end
            else
            begin
                out_hours_reg   <= hours2_reg;
                out_minutes_reg <= fix60 ? min_est_reg + 6'd1 : min_est_reg;
                out_seconds_reg <= fix60 ? 6'(r60 - 12'(60)) : 6'(r60);
            end
        end
    end

    assign out_valid    = v_reg[STAGES-1];
    assign diff_hours   = out_hours_reg;
    assign diff_minutes = out_minutes_reg;
    assign diff_seconds = out_seconds_reg;

endmodule
